@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hbr_pkg.sv @@
package hbr_pkg;

  // Sample and arithmetic widths.
  localparam int SAMPLE_W   = 16;
  localparam int PAIR_W     = SAMPLE_W + 1;
  localparam int COEF_W     = 15;
  localparam int ACC_W      = 32;

  // Filter geometry: 39 taps, folded into ten symmetric pairs plus the center tap.
  localparam int TAP_COUNT  = 39;
  localparam int HIST_DEPTH = TAP_COUNT - 1;
  localparam int PAIRS      = 10;
  // The half-rate line keeps 19 cells; its oldest entry feeds the first folded pair.
  localparam int DEC_CELLS  = (TAP_COUNT + 1) / 2 - 1;
  // Half-rate cell that feeds the center tap on odd items.
  localparam int ODD_TAP    = 9;

  // The center coefficient is 0x4000, so that product is a shift.
  localparam int CTR_SHIFT  = 14;
  localparam int DOWN_SHIFT = 15;
  localparam int UP_SHIFT   = 14;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PAIR_W-1:0]   pair_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Coefficient of even tap 2*j, which equals that of tap 38-2*j.
  localparam coef_t COEF [PAIRS] = '{
    -15'sd1, 15'sd2, -15'sd10, 15'sd35, -15'sd103,
    15'sd266, -15'sd616, 15'sd1332, -15'sd2960, 15'sd10246
  };

  localparam acc_t SAT_HI = 32'sh0000_7FFF;
  localparam acc_t SAT_LO = -32'sh0000_8000;

  // Load enables of the two registered stages inside a folded MAC.
  typedef struct packed {
    logic mul;
    logic part;
  } mac_en_t;

  // Saturate a shifted sum to a 16-bit sample.
  function automatic sample_t sat16(input acc_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = sample_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = sample_t'(SAT_LO);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/hbr_delay_cell.sv @@
module hbr_delay_cell
  import hbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    shift_i,
  input  sample_t data_i,
  output sample_t data_o
);

  sample_t data_q;

  // One delay-line tap: takes its neighbor's sample on each shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ src/hbr_fold_mac.sv @@
module hbr_fold_mac
  import hbr_pkg::*;
(
  input  logic    clk_i,
  input  mac_en_t en_i,
  input  pair_t   pair_i [PAIRS],
  input  sample_t center_i,
  output acc_t    acc_o
);

  acc_t prod_q [PAIRS];
  acc_t ctr_q;
  acc_t part_d [3];
  acc_t part_q [3];

  // Products of the folded pairs with their coefficients; the center tap is a shift.
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int j = 0; j < PAIRS; j++) begin
        prod_q[j] <= acc_t'(pair_i[j]) * acc_t'(COEF[j]);
      end
      ctr_q <= acc_t'(center_i) <<< CTR_SHIFT;
    end
  end

  // First level of the adder tree.
  always_comb begin
    part_d[0] = prod_q[0] + prod_q[1] + prod_q[2] + prod_q[3];
    part_d[1] = prod_q[4] + prod_q[5] + prod_q[6] + prod_q[7];
    part_d[2] = prod_q[8] + prod_q[9] + ctr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      part_q <= part_d;
    end
  end

  // Final add; the caller registers it after shift and saturation.
  assign acc_o = part_q[0] + part_q[1] + part_q[2];

endmodule

@@ src/halfband_fir_resample_round_trip_top.sv @@
// Throughput: one sample per cycle while the output side accepts; set by the
// eight-stage pipeline of two folded FIR sections, each stage with its own valid
// bit so bubbles are squeezed out.
// Reset: asynchronous, active low; clears both delay lines to zero, empties the
// pipeline and sets the phase so the first sample is even.
`include "assert_macros.svh"

module halfband_fir_resample_round_trip_top
  import hbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] up_sample, [31:16] down_sample
  output logic        m_axis_tuser_o    // [0] down_valid
);

  // Pipeline control: stage k loads when it is empty or its content moves on.
  logic [8:1] valid_q;
  logic [8:1] even_q;
  logic [9:1] en;
  logic       phase_odd_q;
  logic       accept;

  always_comb begin
    en[9] = m_axis_tready_i;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign accept          = s_axis_tvalid_i && en[1];
  assign s_axis_tready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      even_q      <= '0;
      phase_odd_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_odd_q <= !phase_odd_q;
      end
      if (en[1]) begin
        valid_q[1] <= s_axis_tvalid_i;
        even_q[1]  <= !phase_odd_q;
      end
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
          even_q[k]  <= even_q[k-1];
        end
      end
    end
  end

  // Full-rate delay line; the window is the new sample plus 38 older ones.
  sample_t hist [HIST_DEPTH];
  sample_t win  [TAP_COUNT];

  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
    if (k == 0) begin : g_head
      hbr_delay_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(accept),
        .data_i (sample_t'(s_axis_tdata_i)),
        .data_o (hist[k])
      );
    end else begin : g_body
      hbr_delay_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(accept),
        .data_i (hist[k-1]),
        .data_o (hist[k])
      );
    end
  end

  always_comb begin
    win[0] = sample_t'(s_axis_tdata_i);
    for (int k = 1; k < TAP_COUNT; k++) begin
      win[k] = hist[k-1];
    end
  end

  // Stage 1: fold the symmetric taps of the decimating filter.
  pair_t   pair1_q [PAIRS];
  sample_t ctr1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int j = 0; j < PAIRS; j++) begin
        pair1_q[j] <= pair_t'(win[2*j]) + pair_t'(win[TAP_COUNT-1-2*j]);
      end
      ctr1_q <= win[(TAP_COUNT-1)/2];
    end
  end

  // Stages 2 and 3: decimator products and partial sums.
  mac_en_t dec_en;
  acc_t    dec_acc;

  assign dec_en.mul  = en[2];
  assign dec_en.part = en[3];

  hbr_fold_mac u_dec_mac (
    .clk_i   (clk_i),
    .en_i    (dec_en),
    .pair_i  (pair1_q),
    .center_i(ctr1_q),
    .acc_o   (dec_acc)
  );

  // Stage 4: decimated sample, zero on odd items.
  sample_t down4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      down4_q <= even_q[3] ? sat16(dec_acc >>> DOWN_SHIFT) : '0;
    end
  end

  // Half-rate delay line, pushed when an even item enters stage 5.
  logic    dec_push;
  sample_t dh   [DEC_CELLS];
  sample_t dwin [DEC_CELLS+1];

  assign dec_push = valid_q[4] && en[5] && even_q[4];

  for (genvar k = 0; k < DEC_CELLS; k++) begin : g_dec
    if (k == 0) begin : g_head
      hbr_delay_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(dec_push),
        .data_i (down4_q),
        .data_o (dh[k])
      );
    end else begin : g_body
      hbr_delay_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(dec_push),
        .data_i (dh[k-1]),
        .data_o (dh[k])
      );
    end
  end

  always_comb begin
    dwin[0] = down4_q;
    for (int k = 1; k <= DEC_CELLS; k++) begin
      dwin[k] = dh[k-1];
    end
  end

  // Stage 5: fold the half-rate window; odd items only need the center cell.
  pair_t   pair5_q [PAIRS];
  sample_t odd5_q, odd6_q, odd7_q;
  sample_t down5_q, down6_q, down7_q, down8_q;
  sample_t up8_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < PAIRS; i++) begin
        pair5_q[i] <= pair_t'(dwin[i]) + pair_t'(dwin[DEC_CELLS-i]);
      end
      odd5_q  <= dh[ODD_TAP];
      down5_q <= down4_q;
    end
    if (en[6]) begin
      odd6_q  <= odd5_q;
      down6_q <= down5_q;
    end
    if (en[7]) begin
      odd7_q  <= odd6_q;
      down7_q <= down6_q;
    end
  end

  // Stages 6 and 7: interpolator products and partial sums.
  mac_en_t int_en;
  acc_t    int_acc;

  assign int_en.mul  = en[6];
  assign int_en.part = en[7];

  hbr_fold_mac u_int_mac (
    .clk_i   (clk_i),
    .en_i    (int_en),
    .pair_i  (pair5_q),
    .center_i('0),
    .acc_o   (int_acc)
  );

  // Stage 8: output register.
  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      up8_q   <= even_q[7] ? sat16(int_acc >>> UP_SHIFT) : odd7_q;
      down8_q <= down7_q;
    end
  end

  assign m_axis_tvalid_o = valid_q[8];
  assign m_axis_tdata_o  = {down8_q, up8_q};
  assign m_axis_tuser_o  = even_q[8];

  // Checks on the pipeline and the phase tracking.
  `ASSERT_IMPLIES(a_stall_only_when_full, clk_i, rst_ni, !s_axis_tready_o, &valid_q,
                  "input stalled with a bubble in the pipeline")
  `ASSERT_IMPLIES(a_parity_alternates, clk_i, rst_ni, valid_q[4] && valid_q[5],
                  even_q[4] != even_q[5], "neighboring items share a phase")
  `ASSERT_IMPLIES(a_odd_down_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o,
                  m_axis_tdata_o[31:16] == 16'h0000, "odd result carries a decimated sample")
  `ASSERT_NEXT(a_push_even_item, clk_i, rst_ni, dec_push, valid_q[5] && even_q[5],
               "half-rate line pushed without an even item moving on")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import hbr_pkg::*;
();

  localparam int DEC_N        = (TAP_COUNT + 1) / 2;
  localparam int RAND_ITEMS   = 1576;
  localparam int QUIET_ITEMS  = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_REPORTS  = 50;

  // Half-band taps in units of 1/32768, tap 0 applied to the newest sample.
  localparam int TAPS [TAP_COUNT] = '{
    -1, 0, 2, 0, -10, 0, 35, 0, -103, 0, 266, 0, -616, 0, 1332, 0, -2960, 0,
    10246, 16384, 10246,
    0, -2960, 0, 1332, 0, -616, 0, 266, 0, -103, 0, 35, 0, -10, 0, 2, 0, -1
  };

  // One output transaction: up_sample, down_sample and down_valid.
  typedef struct packed {
    sample_t up;
    sample_t down;
    logic    dvalid;
  } rt_result_t;

  // One directed stimulus row; typed rows carry a hand-written expectation.
  typedef struct packed {
    sample_t    value;
    logic       typed;
    rt_result_t want;
  } stim_row_t;

  typedef enum int {GEN_UNIFORM, GEN_SQUARE, GEN_TAP_BURST, GEN_SMALL, GEN_EXTREME} gen_mode_e;

  // While both histories are still zero, the up and down samples are zero.
  localparam rt_result_t EVEN_ZERO = '{up: 16'sh0000, down: 16'sh0000, dvalid: 1'b1};
  localparam rt_result_t ODD_ZERO  = '{up: 16'sh0000, down: 16'sh0000, dvalid: 1'b0};
  localparam rt_result_t NO_WANT   = '{up: 16'sh0000, down: 16'sh0000, dvalid: 1'b0};

  // Extremes, single-bit and alternating-bit values, then full-scale steps.
  // Odd items before the tenth decimated sample read a zero center cell.
  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{value: 16'sh0000, typed: 1'b1, want: EVEN_ZERO},
    '{value: 16'sh8000, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh0001, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'shFFFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh5555, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'shAAAA, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh7FFF, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh7FFF, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh7FFF, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh7FFF, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh7FFF, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh7FFF, typed: 1'b1, want: ODD_ZERO},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT},
    '{value: 16'sh8000, typed: 1'b0, want: NO_WANT}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // Predictor state: full-rate and half-rate delay lines plus the phase bit.
  sample_t in_hist [TAP_COUNT-1];
  sample_t dec_hist [DEC_N];
  logic    odd_phase;

  rt_result_t resamp_q [$];

  int err_cnt      = 0;
  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int clip_up_cnt  = 0;
  int clip_dn_cnt  = 0;
  int idle_pct     = 0;
  int stall_left   = 0;
  int stuck_cycles = 0;

  // Stimulus generator state.
  gen_mode_e gen_mode  = GEN_UNIFORM;
  int        gen_left  = 0;
  int        sq_half   = 1;
  int        sq_cnt    = 1;
  logic      sq_level  = 1'b0;
  int        burst_end = 0;
  logic      burst_pol = 1'b0;

  halfband_fir_resample_round_trip_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // Clamp a shifted sum to 16 bits and count the clipped cases.
  function automatic sample_t clamp16(input longint v, inout int clips);
    sample_t r;
    if (v > 32767) begin
      r = 16'sh7FFF;
      clips++;
    end else if (v < -32768) begin
      r = 16'sh8000;
      clips++;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Decimate on even samples, then interpolate the zero-stuffed half-rate stream.
  function automatic rt_result_t predict_round_trip(input sample_t x);
    longint     acc;
    sample_t    down;
    rt_result_t res;
    down = '0;
    if (!odd_phase) begin
      acc = longint'(x) * TAPS[0];
      for (int i = 1; i < TAP_COUNT; i++) begin
        acc += longint'(in_hist[i-1]) * TAPS[i];
      end
      down = clamp16(acc >>> 15, clip_dn_cnt);
      for (int i = DEC_N - 1; i > 0; i--) begin
        dec_hist[i] = dec_hist[i-1];
      end
      dec_hist[0] = down;
    end
    acc = 0;
    for (int i = 0; i < DEC_N; i++) begin
      if (!odd_phase) begin
        acc += longint'(dec_hist[i]) * TAPS[2*i];
      end else if (2 * i + 1 < TAP_COUNT) begin
        acc += longint'(dec_hist[i]) * TAPS[2*i+1];
      end
    end
    for (int i = TAP_COUNT - 2; i > 0; i--) begin
      in_hist[i] = in_hist[i-1];
    end
    in_hist[0] = x;
    res.up     = clamp16(acc >>> 14, clip_up_cnt);
    res.down   = down;
    res.dvalid = !odd_phase;
    odd_phase  = !odd_phase;
    return res;
  endfunction

  // Random sample source: noise, full-scale square waves, windows matched to the
  // tap signs (drive the decimator into clipping), small values and extremes.
  function automatic sample_t next_stimulus();
    sample_t     v;
    logic [31:0] rnd;
    int          d;
    int          s;
    int          pick;
    if (gen_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        gen_mode = GEN_UNIFORM;
        gen_left = $urandom_range(8, 64);
      end else if (pick < 55) begin
        gen_mode = GEN_SQUARE;
        sq_half  = $urandom_range(2, 60);
        sq_cnt   = sq_half;
        sq_level = 1'($urandom_range(0, 1));
        gen_left = $urandom_range(2, 5) * 2 * sq_half;
      end else if (pick < 75) begin
        gen_mode  = GEN_TAP_BURST;
        burst_end = sent_cnt + TAP_COUNT - 1;
        if (burst_end % 2 != 0) begin
          burst_end++;
        end
        burst_pol = 1'($urandom_range(0, 1));
        gen_left  = burst_end - sent_cnt + 1;
      end else if (pick < 88) begin
        gen_mode = GEN_SMALL;
        gen_left = $urandom_range(8, 40);
      end else begin
        gen_mode = GEN_EXTREME;
        gen_left = $urandom_range(8, 40);
      end
    end
    rnd = $urandom;
    case (gen_mode)
      GEN_SQUARE: begin
        v = sq_level ? 16'sh7FFF : 16'sh8000;
        sq_cnt--;
        if (sq_cnt == 0) begin
          sq_cnt   = sq_half;
          sq_level = !sq_level;
        end
      end
      GEN_TAP_BURST: begin
        d = burst_end - sent_cnt;
        // A sample older than the window only fills the gap before it.
        if (d >= TAP_COUNT) begin
          v = rnd[15:0];
        end else if (TAPS[d] == 0) begin
          v = rnd[15:0];
        end else begin
          v = ((TAPS[d] > 0) ^ burst_pol) ? 16'sh7FFF : 16'sh8000;
        end
      end
      GEN_SMALL: begin
        s = int'($urandom_range(0, 16)) - 8;
        v = s[15:0];
      end
      GEN_EXTREME: begin
        case (rnd[2:0])
          3'd0:    v = 16'sh7FFF;
          3'd1:    v = 16'sh8000;
          3'd2:    v = 16'sh0000;
          3'd3:    v = 16'shFFFF;
          3'd4:    v = 16'sh0001;
          3'd5:    v = 16'sh7FFE;
          default: v = 16'sh8001;
        endcase
      end
      default: begin
        v = rnd[15:0];
      end
    endcase
    gen_left--;
    return v;
  endfunction

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(input string what, input int idx, input longint got,
                                 input longint want);
    if (err_cnt < MAX_REPORTS) begin
      $display("tb_top: result %0d, %s: got %0d, expected %0d", idx, what, got, want);
    end
    err_cnt++;
  endtask

  // Offer one sample, after an optional gap, and predict it once accepted.
  task automatic send_sample(input sample_t value, input logic typed, input rt_result_t want);
    rt_result_t pred;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_round_trip(value);
    resamp_q.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  // Reset, the directed table, the random stream, then drain and verdict.
  initial begin : stimulus
    foreach (in_hist[i]) in_hist[i] = '0;
    foreach (dec_hist[i]) dec_hist[i] = '0;
    odd_phase = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_sample(DIR_TABLE[r].value, DIR_TABLE[r].typed, DIR_TABLE[r].want);
    end

    // Idling rate changes every hundred samples; the tail runs with none.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n >= RAND_ITEMS - QUIET_ITEMS) begin
        idle_pct = 0;
      end else if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 8;
          2:       idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end
      send_sample(next_stimulus(), 1'b0, NO_WANT);
    end
    s_tvalid <= 1'b0;

    while (resamp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb_top: %0d samples streamed, %0d results checked", sent_cnt, checked_cnt);
    $display("tb_top: clipping hit on %0d decimated and %0d interpolated samples",
             clip_dn_cnt, clip_up_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Output side backpressure in random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_tready   <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    rt_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (resamp_q.size() == 0) begin
        report_mismatch("unexpected transaction", checked_cnt, m_axis_tdata_o, 0);
      end else begin
        want = resamp_q.pop_front();
        if ($signed(m_axis_tdata_o[15:0]) != want.up) begin
          report_mismatch("up_sample", checked_cnt, $signed(m_axis_tdata_o[15:0]), want.up);
        end
        if ($signed(m_axis_tdata_o[31:16]) != want.down) begin
          report_mismatch("down_sample", checked_cnt, $signed(m_axis_tdata_o[31:16]),
                          want.down);
        end
        if (m_axis_tuser_o !== want.dvalid) begin
          report_mismatch("down_valid", checked_cnt, m_axis_tuser_o, want.dvalid);
        end
      end
      checked_cnt++;
    end
  end

  // Watchdog: end the run if neither side moves a transaction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("tb_top: no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, resamp_q.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

endmodule
